### hdl/sui_pkg.sv
// Shared constants, payload types and controller states for the sort/dedup block.
package sui_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ID_BITS   = 19;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic [ID_BITS-1:0] vertex_id;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic [ID_BITS-1:0] unique_value;
    logic [CNT_W-1:0]   unique_count;
    logic               last_result;
    logic               items_dropped;
  } out_t;

  typedef enum logic [1:0] {
    S_FILL,
    S_SCAN,
    S_DRAIN,
    S_SEND
  } state_e;

endpackage

### hdl/sui_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sui_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sort_unique_ids.sv
// Operation: one input transfer per cycle while loading; after the marked last item,
// (U+1) scan passes count the U distinct values of the N stored, then each result
// takes one more pass plus a load of the output register, which waits while the
// output is stalled. Every pass is one full read sweep of the value RAM (one read port).
// Reset clears all control state and counts; RAM contents stay undefined and are
// never read before being written for the current list.
module sort_unique_ids (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sui_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sui_pkg::out_t  out_data_o
);

  localparam int unsigned AW = sui_pkg::ADDR_W;
  localparam int unsigned CW = sui_pkg::CNT_W;
  localparam int unsigned IW = sui_pkg::ID_BITS;

  sui_pkg::state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          cmp_valid_q, cmp_valid_d;
  logic [IW-1:0] best_q, best_d;
  logic          found_q, found_d;
  logic [IW-1:0] thr_q, thr_d;
  logic          have_thr_q, have_thr_d;
  logic          emit_q, emit_d;
  logic [CW-1:0] uniq_q, uniq_d;
  logic [CW-1:0] sent_q, sent_d;
  logic          out_valid_q, out_valid_d;
  sui_pkg::out_t out_q, out_d;

  logic          in_xfer;
  logic          has_room;
  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_rdata;
  logic          cand_ok;
  logic          scan_end;
  logic          out_free;
  logic          send_last;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign has_room  = fill_q < CW'(sui_pkg::MAX_ITEMS);
  assign scan_end  = CW'(idx_q) == (fill_q - CW'(1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign send_last = (sent_q + CW'(1)) == uniq_q;

  // Candidate: above the last value taken and below the best seen this pass.
  assign cand_ok = cmp_valid_q && (!have_thr_q || ram_rdata > thr_q) &&
                   (!found_q || ram_rdata < best_q);
  assign best_d  = cand_ok ? ram_rdata : best_q;

  // Fill writes and scan reads never share a cycle, so no forwarding is needed.
  sui_ram #(
    .WIDTH (IW),
    .DEPTH (sui_pkg::MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (in_data_i.vertex_id),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sui_pkg::S_FILL: begin
        if (in_xfer && in_data_i.is_last) begin
          state_d = sui_pkg::S_SCAN;
        end
      end
      sui_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = sui_pkg::S_DRAIN;
        end
      end
      sui_pkg::S_DRAIN: begin
        if (emit_q) begin
          state_d = sui_pkg::S_SEND;
        end else begin
          state_d = sui_pkg::S_SCAN;
        end
      end
      sui_pkg::S_SEND: begin
        if (out_free) begin
          state_d = send_last ? sui_pkg::S_FILL : sui_pkg::S_SCAN;
        end
      end
      default: state_d = sui_pkg::S_FILL;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    cmp_valid_d = 1'b0;
    found_d     = found_q | cand_ok;
    thr_d       = thr_q;
    have_thr_d  = have_thr_q;
    emit_d      = emit_q;
    uniq_d      = uniq_q;
    sent_d      = sent_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      sui_pkg::S_FILL: begin
        in_ready_o = 1'b1;
        // Ready is always high here, so valid alone marks a transfer.
        if (in_valid_i) begin
          if (has_room) begin
            ram_we = 1'b1;
            fill_d = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.is_last) begin
            idx_d      = '0;
            found_d    = 1'b0;
            have_thr_d = 1'b0;
            emit_d     = 1'b0;
            uniq_d     = '0;
            sent_d     = '0;
          end
        end
      end
      sui_pkg::S_SCAN: begin
        ram_re      = 1'b1;
        cmp_valid_d = 1'b1;
        idx_d       = idx_q + AW'(1);
      end
      sui_pkg::S_DRAIN: begin
        idx_d   = '0;
        found_d = 1'b0;
        if (emit_q) begin
          thr_d      = best_d;
          have_thr_d = 1'b1;
        end else if (found_q || cand_ok) begin
          uniq_d     = uniq_q + CW'(1);
          thr_d      = best_d;
          have_thr_d = 1'b1;
        end else begin
          // Count known: rescan from the smallest value and emit.
          emit_d     = 1'b1;
          have_thr_d = 1'b0;
        end
      end
      sui_pkg::S_SEND: begin
        found_d = 1'b0;
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.unique_value  = thr_q;
          out_d.unique_count  = uniq_q;
          out_d.last_result   = send_last;
          out_d.items_dropped = ovf_q;
          sent_d              = sent_q + CW'(1);
          if (send_last) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sui_pkg::S_FILL;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      have_thr_q  <= 1'b0;
      emit_q      <= 1'b0;
      uniq_q      <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      found_q     <= found_d;
      have_thr_q  <= have_thr_d;
      emit_q      <= emit_d;
      uniq_q      <= uniq_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    thr_q  <= thr_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
